>>> rtl/csvfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // default module parameters
    localparam int CSVFS_WIDTH_SLOTS     = 8;
    localparam int CSVFS_LINE_COUNT_BITS = 32;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int LINE_OUT_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // line feed byte
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTHS = 2'd2;

    // configuration register reset values
    localparam logic [BYTE_W-1:0]     DELIM_RESET  = 8'd44;
    localparam logic [BYTE_W-1:0]     QUOTE_RESET  = 8'd34;
    localparam logic [CFG_DATA_W-1:0] WIDTHS_RESET = '1;

    // result kinds
    localparam logic RES_CONTENT = 1'b0;
    localparam logic RES_END     = 1'b1;

    // configuration as seen by the parser
    typedef struct packed {
        logic [BYTE_W-1:0]     delim;
        logic [BYTE_W-1:0]     quote;
        logic [CFG_DATA_W-1:0] widths;
    } t_cfg;

    // all results caused by one input byte: an optional content byte,
    // then an optional end-of-field marker
    typedef struct packed {
        logic                  has_content;
        logic [BYTE_W-1:0]     content_byte;
        logic                  has_end;
        logic [BYTE_W-1:0]     field_index;
        logic [LINE_OUT_W-1:0] line_number;
        logic [BYTE_W-1:0]     field_length;
        logic                  ends_line;
    } t_run;

endpackage

>>> rtl/csvfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_if
// Channel interfaces: input byte, result and configuration write.
// ----------------------------------------------------------------------------
interface csvfs_byte_if;
    import csvfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface csvfs_res_if;
    import csvfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  result_kind;
    logic [BYTE_W-1:0]     content_byte;
    logic [BYTE_W-1:0]     field_index;
    logic [LINE_OUT_W-1:0] line_number;
    logic [BYTE_W-1:0]     field_length;
    logic                  ends_line;
    logic                  last_of_run;

    modport source (output valid, output result_kind, output content_byte,
                    output field_index, output line_number, output field_length,
                    output ends_line, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input content_byte,
                    input field_index, input line_number, input field_length,
                    input ends_line, input last_of_run, output ready);
endinterface

interface csvfs_cfg_if;
    import csvfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/csv_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV byte stream into content words and end-of-field markers.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  i_in     in   data_byte: one byte of CSV text
//  o_out    out  result: content byte or end-of-field marker
//  i_cfg    in   register write: index, data (delimiter, quote, widths)
//
// One byte is accepted per cycle while the result queue has room; the parser
// runs between the input register and a two-entry result queue. A byte that
// causes two words (content then end marker) keeps its queue entry until both
// are sent; the input stalls only once both entries are full. Synchronous
// active-low reset; no clearing pass. Stalls on o_out back up through the
// queue to i_in.ready.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
    parameter int WIDTH_SLOTS     = csvfs_pkg::CSVFS_WIDTH_SLOTS,
    parameter int LINE_COUNT_BITS = csvfs_pkg::CSVFS_LINE_COUNT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csvfs_byte_if.sink    i_in,
    csvfs_cfg_if.sink     i_cfg,
    csvfs_res_if.source   o_out
);
    import csvfs_pkg::*;

    t_cfg r_cfg;
    t_run run;
    logic push;
    logic q_full;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim  <= DELIM_RESET;
            r_cfg.quote  <= QUOTE_RESET;
            r_cfg.widths <= WIDTHS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DELIM:  r_cfg.delim  <= i_cfg.data[BYTE_W-1:0];
                REG_QUOTE:  r_cfg.quote  <= i_cfg.data[BYTE_W-1:0];
                REG_WIDTHS: r_cfg.widths <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // parser
    csvfs_core #(
        .WIDTH_SLOTS     (WIDTH_SLOTS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.data_byte),
        .o_ready  (i_in.ready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_run    (run)
    );

    // result queue
    csvfs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .o_full  (q_full),
        .o_out   (o_out)
    );

endmodule

>>> rtl/csvfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_core
// Input register and per-byte parser: field, quote and width tracking.
// ----------------------------------------------------------------------------
module csvfs_core #(
    parameter int WIDTH_SLOTS     = csvfs_pkg::CSVFS_WIDTH_SLOTS,
    parameter int LINE_COUNT_BITS = csvfs_pkg::CSVFS_LINE_COUNT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  csvfs_pkg::t_cfg          i_cfg,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    output logic                     o_ready,
    input  logic                     i_q_full,
    output logic                     o_push,
    output csvfs_pkg::t_run          o_run
);
    import csvfs_pkg::*;

    // parser actions
    localparam logic [1:0] ACT_TAKE = 2'd0;
    localparam logic [1:0] ACT_END  = 2'd1;
    localparam logic [1:0] ACT_OPEN = 2'd2;
    localparam logic [1:0] ACT_ESC  = 2'd3;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // parser state
    logic                       r_fld_open,  n_fld_open;
    logic                       r_quoted,    n_quoted;
    logic                       r_skipping,  n_skipping;
    logic [BYTE_W-1:0]          r_prev,      n_prev;
    logic                       r_prev_vld,  n_prev_vld;
    logic [BYTE_W-1:0]          r_held,      n_held;
    logic                       r_held_vld,  n_held_vld;
    logic [BYTE_W-1:0]          r_pos,       n_pos;
    logic [BYTE_W-1:0]          r_fcount,    n_fcount;
    logic [LINE_COUNT_BITS-1:0] r_line,      n_line;

    logic              advance;
    logic              is_lf, is_delim, is_quote, pending;
    logic              drop;
    logic [1:0]        act;
    logic [BYTE_W-1:0] width;
    logic [63:0]       line_ext;
    t_run              run;

    assign advance = r_in_valid && !i_q_full;
    assign o_ready = !r_in_valid || !i_q_full;
    assign o_run   = run;
    assign o_push  = advance && (run.has_content || run.has_end);

    assign line_ext = 64'(r_line);

    // byte classes
    assign is_lf    = r_in_byte == LF_BYTE;
    assign is_delim = r_in_byte == i_cfg.delim;
    assign is_quote = r_in_byte == i_cfg.quote;
    assign pending  = r_quoted && r_prev_vld && (r_prev == i_cfg.quote);
    assign drop     = pending && !r_skipping && r_held_vld;

    // width limit of the current field; past the table it is 255
    always_comb begin
        width = '1;
        for (int i = 0; i < WIDTH_SLOTS; i++) begin
            if (r_fcount == 8'(i)) width = i_cfg.widths[8*i +: 8];
        end
    end

    // pick the action for this byte
    always_comb begin
        if (is_lf) begin
            act = ACT_END;
        end else if (!r_fld_open) begin
            if (is_delim)      act = ACT_END;
            else if (is_quote) act = ACT_OPEN;
            else               act = ACT_TAKE;
        end else if (r_quoted) begin
            if (pending && is_quote)      act = ACT_ESC;
            else if (pending && is_delim) act = ACT_END;
            else                          act = ACT_TAKE;
        end else begin
            if (is_delim) act = ACT_END;
            else          act = ACT_TAKE;
        end
    end

    // next state and results
    always_comb begin
        n_fld_open  = r_fld_open;
        n_quoted    = r_quoted;
        n_skipping  = r_skipping;
        n_prev      = r_prev;
        n_prev_vld  = r_prev_vld;
        n_held      = r_held;
        n_held_vld  = r_held_vld;
        n_pos       = r_pos;
        n_fcount    = r_fcount;
        n_line      = r_line;

        run              = '0;
        run.field_index  = r_fcount;
        run.line_number  = line_ext[LINE_OUT_W-1:0];
        run.content_byte = r_held;

        unique case (act)
            ACT_TAKE: begin
                n_fld_open = 1'b1;
                n_prev     = r_in_byte;
                n_prev_vld = 1'b1;
                if (r_pos < width) begin
                    run.has_content = r_held_vld;
                    n_held          = r_in_byte;
                    n_held_vld      = 1'b1;
                    n_pos           = r_pos + 8'd1;
                end else begin
                    n_skipping = 1'b1;
                end
            end
            ACT_END: begin
                // a trailing closing quote is withdrawn
                run.has_content  = r_held_vld && !drop;
                run.has_end      = 1'b1;
                run.field_length = r_pos - {7'd0, drop};
                run.ends_line    = is_lf;
                n_fld_open  = 1'b0;
                n_quoted    = 1'b0;
                n_skipping  = 1'b0;
                n_prev      = '0;
                n_prev_vld  = 1'b0;
                n_held      = '0;
                n_held_vld  = 1'b0;
                n_pos       = '0;
                if (is_lf) begin
                    n_fcount = '0;
                    n_line   = r_line + LINE_COUNT_BITS'(1);
                end else if (r_fcount != 8'hFF) begin
                    n_fcount = r_fcount + 8'd1;
                end
            end
            ACT_OPEN: begin
                n_fld_open  = 1'b1;
                n_quoted    = 1'b1;
                n_prev_vld  = 1'b0;
            end
            ACT_ESC: begin
                // doubled quote: the first one already stands as content
                n_prev_vld = 1'b0;
            end
            default: ;
        endcase
    end

    // input register and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fld_open  <= 1'b0;
            r_quoted    <= 1'b0;
            r_skipping  <= 1'b0;
            r_prev      <= '0;
            r_prev_vld  <= 1'b0;
            r_held      <= '0;
            r_held_vld  <= 1'b0;
            r_pos       <= '0;
            r_fcount    <= '0;
            r_line      <= LINE_COUNT_BITS'(1);
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (advance) begin
                r_fld_open  <= n_fld_open;
                r_quoted    <= n_quoted;
                r_skipping  <= n_skipping;
                r_prev      <= n_prev;
                r_prev_vld  <= n_prev_vld;
                r_held      <= n_held;
                r_held_vld  <= n_held_vld;
                r_pos       <= n_pos;
                r_fcount    <= n_fcount;
                r_line      <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_byte;
    end

endmodule

>>> rtl/csvfs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_outq
// Two-entry result queue; each entry sends one or two result words.
// ----------------------------------------------------------------------------
module csvfs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csvfs_pkg::t_run   i_run,
    output logic              o_full,
    csvfs_res_if.source       o_out
);
    import csvfs_pkg::*;

    t_run       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;

    t_run head;
    logic first_content;
    logic last;
    logic take;

    assign o_full = r_count == 2'd2;
    assign head   = r_mem[r_rd_ptr];

    // content word goes first when the entry has one
    assign first_content = head.has_content && !r_sub;
    assign last          = first_content ? !head.has_end : 1'b1;
    assign take          = o_out.valid && o_out.ready;

    assign o_out.valid        = r_count != 2'd0;
    assign o_out.result_kind  = first_content ? RES_CONTENT : RES_END;
    assign o_out.content_byte = first_content ? head.content_byte : '0;
    assign o_out.field_index  = head.field_index;
    assign o_out.line_number  = head.line_number;
    assign o_out.field_length = first_content ? '0 : head.field_length;
    assign o_out.ends_line    = first_content ? 1'b0 : head.ends_line;
    assign o_out.last_of_run  = last;

    // pointers, fill count and word select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (take) begin
                if (last) begin
                    r_rd_ptr <= !r_rd_ptr;
                    r_sub    <= 1'b0;
                end else begin
                    r_sub <= 1'b1;
                end
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, take && last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_run;
    end

endmodule

>>> dv/csv_field_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter_tb
// Self-checking bench for the CSV field splitter. Bytes of CSV text go in on
// the input channel. A small tracker class predicts every content word and
// end-of-field marker and checks the result channel against it in order.
// Phases cover several delimiter, quote and width settings. Random records
// with noise come after a short directed stream.
// ----------------------------------------------------------------------------
module csv_field_splitter_tb;
    import csvfs_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_TRICKLE, SINK_PERIODIC} t_sink_mode;

    // one expected or observed result word
    typedef struct packed {
        logic                  kind;
        logic [BYTE_W-1:0]     data;
        logic [BYTE_W-1:0]     col;
        logic [LINE_OUT_W-1:0] line_no;
        logic [BYTE_W-1:0]     len;
        logic                  eol;
        logic                  last;
    } t_split_word;

    // field splitting tracker: parser state, configuration, pending words
    class field_split_tracker;
        t_split_word       expected_q[$];
        int                errors;
        logic [BYTE_W-1:0] delim;
        logic [BYTE_W-1:0] quote;
        logic [63:0]       widths;
        bit                field_open;
        bit                quoted;
        bit                skipping;
        bit                prev_valid;
        bit                held_valid;
        logic [BYTE_W-1:0] prev_byte;
        logic [BYTE_W-1:0] held_byte;
        logic [BYTE_W-1:0] field_pos;
        logic [BYTE_W-1:0] field_cnt;
        logic [31:0]       line_cnt;

        function new();
            errors     = 0;
            delim      = DELIM_RESET;
            quote      = QUOTE_RESET;
            widths     = WIDTHS_RESET;
            field_open = 0;
            quoted     = 0;
            skipping   = 0;
            prev_valid = 0;
            held_valid = 0;
            prev_byte  = '0;
            held_byte  = '0;
            field_pos  = '0;
            field_cnt  = '0;
            line_cnt   = 32'd1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_DELIM:  delim  = value[BYTE_W-1:0];
                REG_QUOTE:  quote  = value[BYTE_W-1:0];
                REG_WIDTHS: widths = value;
                default: ;
            endcase
        endfunction

        function void emit(logic kind, logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] len,
                           logic eol);
            t_split_word w;
            w.kind    = kind;
            w.data    = data;
            w.col     = field_cnt;
            w.line_no = line_cnt;
            w.len     = len;
            w.eol     = eol;
            w.last    = 1'b0;
            expected_q.push_back(w);
        endfunction

        // width limit of the current column; columns past the table get 255
        function logic [BYTE_W-1:0] width_now();
            if (field_cnt < CSVFS_WIDTH_SLOTS)
                return widths[8*int'(field_cnt) +: 8];
            return 8'hFF;
        endfunction

        // content byte: release the held one, hold the new one (or skip it)
        function void store_byte(logic [BYTE_W-1:0] c);
            prev_byte  = c;
            prev_valid = 1;
            if (field_pos < width_now()) begin
                if (held_valid)
                    emit(RES_CONTENT, held_byte, '0, 1'b0);
                held_byte  = c;
                held_valid = 1;
                field_pos++;
            end else begin
                skipping = 1;
            end
        endfunction

        // field end; a held closing quote is withdrawn
        function void close_field(bit eol, bit pend);
            bit                drop;
            logic [BYTE_W-1:0] len;
            drop = pend && !skipping && held_valid;
            len  = field_pos;
            if (held_valid) begin
                if (drop)
                    len--;
                else
                    emit(RES_CONTENT, held_byte, '0, 1'b0);
            end
            emit(RES_END, '0, len, eol);
            field_open = 0;
            quoted     = 0;
            skipping   = 0;
            prev_byte  = '0;
            prev_valid = 0;
            held_byte  = '0;
            held_valid = 0;
            field_pos  = '0;
            if (eol) begin
                field_cnt = '0;
                line_cnt++;
            end else if (field_cnt != 8'hFF) begin
                field_cnt++;
            end
        endfunction

        // accepted input word: queue the words it causes
        function void note_byte(logic [BYTE_W-1:0] c);
            int n0;
            bit is_delim;
            bit is_quote;
            bit pend;
            n0       = expected_q.size();
            is_delim = (c == delim);
            is_quote = (c == quote);
            pend     = quoted && prev_valid && (prev_byte == quote);
            if (c == LF_BYTE) begin
                close_field(1, pend);
            end else if (!field_open) begin
                if (is_delim) begin
                    close_field(0, 0);
                end else begin
                    field_open = 1;
                    if (is_quote) begin
                        quoted     = 1;
                        prev_valid = 0;
                    end else begin
                        store_byte(c);
                    end
                end
            end else if (quoted) begin
                if (pend && is_quote)
                    prev_valid = 0;
                else if (pend && is_delim)
                    close_field(0, 1);
                else
                    store_byte(c);
            end else if (is_delim) begin
                close_field(0, 0);
            end else begin
                store_byte(c);
            end
            if (expected_q.size() > n0)
                expected_q[expected_q.size()-1].last = 1'b1;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (errors < 40)
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
                errors++;
            end
        endfunction

        // accepted result word against the oldest expectation
        function void check_word(t_split_word got);
            t_split_word want;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with none expected, expected nothing, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("result_kind",  want.kind,    got.kind);
            compare("content_byte", want.data,    got.data);
            compare("field_index",  want.col,     got.col);
            compare("line_number",  want.line_no, got.line_no);
            compare("field_length", want.len,     got.len);
            compare("ends_line",    want.eol,     got.eol);
            compare("last_of_run",  want.last,    got.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csvfs_byte_if in_if();
    csvfs_cfg_if  cfg_if();
    csvfs_res_if  out_if();

    csv_field_splitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    field_split_tracker splitter = new();

    int         burst_left = 0;
    int         gap_due    = 0;
    int         pushed     = 0;
    int         idle_cycles = 0;
    int         stall_run  = 0;
    int         sink_tick  = 0;
    t_sink_mode stall_mode = SINK_OPEN;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stalls: modes held for random stretches
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_sink_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(20, 200);
        end else begin
            stall_run--;
        end
        sink_tick++;
        case (stall_mode)
            SINK_OPEN:     out_if.ready <= 1'b1;
            SINK_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
            SINK_TRICKLE:  out_if.ready <= ($urandom_range(0, 7) == 0);
            default:       out_if.ready <= (sink_tick % 8 != 0);
        endcase
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        t_split_word got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.kind    = out_if.result_kind;
                got.data    = out_if.content_byte;
                got.col     = out_if.field_index;
                got.line_no = out_if.line_number;
                got.len     = out_if.field_length;
                got.eol     = out_if.ends_line;
                got.last    = out_if.last_of_run;
                splitter.check_word(got);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("csv_field_splitter_tb failed");
                $finish;
            end
        end
    end

    // one input word; the sender runs in bursts with gaps between them
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if (gap_due > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap_due) @(posedge i_clk);
            gap_due = 0;
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        splitter.note_byte(b);
        pushed++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_due    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // one register write, then the channel goes idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        splitter.set_reg(idx, value);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop input, wait for every expected word, then let the pipe drain
    task automatic settle();
        in_if.valid <= 1'b0;
        while (splitter.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // letters, quote and delimiter are favoured; otherwise any byte
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'd97 + 8'($urandom_range(0, 25));
        if (r == 4)
            return splitter.quote;
        if (r == 5)
            return splitter.delim;
        return 8'($urandom_range(0, 255));
    endfunction

    // content of an unquoted field: no delimiter, no line feed, no leading quote
    function automatic logic [BYTE_W-1:0] plain_byte(input bit first);
        logic [BYTE_W-1:0] c;
        do
            c = pick_byte();
        while (c == splitter.delim || c == LF_BYTE || (first && c == splitter.quote));
        return c;
    endfunction

    function automatic logic [63:0] rand_widths(input int maxw);
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = 8'($urandom_range(0, maxw));
        return w;
    endfunction

    // one line of fields, mostly well formed, some broken on purpose
    task automatic send_record();
        int                nf;
        int                flen;
        int                r;
        logic [BYTE_W-1:0] c;
        nf = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0) begin
                // quoted field, inner quotes doubled
                push_byte(splitter.quote);
                for (int i = 0; i < flen; i++) begin
                    do c = pick_byte(); while (c == LF_BYTE);
                    push_byte(c);
                    if (c == splitter.quote)
                        push_byte(splitter.quote);
                end
                r = $urandom_range(0, 9);
                if (r != 0)
                    push_byte(splitter.quote);
                if (r == 1)
                    push_byte(plain_byte(1'b0));
            end else begin
                for (int i = 0; i < flen; i++)
                    push_byte(plain_byte(i == 0));
            end
            if ($urandom_range(0, 19) != 0)
                push_byte((f == nf - 1) ? LF_BYTE : splitter.delim);
        end
    endtask

    // program all registers, then random records and noise
    task automatic run_phase(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] q,
                             input logic [63:0] w, input int budget);
        int start;
        int n;
        write_reg(REG_DELIM, {56'd0, d});
        write_reg(REG_QUOTE, {56'd0, q});
        write_reg(REG_WIDTHS, w);
        start = pushed;
        while (pushed - start < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end else begin
                send_record();
            end
        end
        push_byte(LF_BYTE);
        settle();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= REG_DELIM;
        cfg_if.data      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty fields, quote in plain field, escaped quote,
        // text after closing quote, line feed inside quotes, byte extremes
        push_text(",\na\"b,\"x\"\"y\",\"p\"q,\n\"z\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(LF_BYTE);
        settle();

        run_phase(DELIM_RESET, QUOTE_RESET, WIDTHS_RESET, 135);
        run_phase(8'd9, 8'd39, rand_widths(5), 135);
        run_phase(8'd0, 8'd255, 64'd0, 125);
        run_phase(8'd255, 8'd0, rand_widths(12), 135);
        run_phase(8'd59, 8'd59, rand_widths(8), 135);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  {32'($urandom), 32'($urandom)}, 135);
        run_phase(DELIM_RESET, QUOTE_RESET, rand_widths(255), 135);

        // width 255 overrun on one long field, then column saturation
        write_reg(REG_WIDTHS, WIDTHS_RESET);
        for (int i = 0; i < 260; i++)
            push_byte(8'd120);
        push_byte(splitter.delim);
        for (int i = 0; i < 270; i++)
            push_byte(splitter.delim);
        push_byte(LF_BYTE);
        settle();

        if (splitter.errors == 0 && splitter.expected_q.size() == 0)
            $display("csv_field_splitter_tb passed");
        else
            $display("csv_field_splitter_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/csvfs_pkg.sv
rtl/csvfs_if.sv
rtl/csvfs_core.sv
rtl/csvfs_outq.sv
rtl/csv_field_splitter.sv
dv/csv_field_splitter_tb.sv
